/* rtl/image_scaler_nn_bilinear_bicubic_top_assert.svh */
// Assertion macros for the image scaler top level.
// Used by image_scaler_nn_bilinear_bicubic_top.sv; no other dependencies.
`ifndef IMAGE_SCALER_NN_BILINEAR_BICUBIC_TOP_ASSERT_SVH
`define IMAGE_SCALER_NN_BILINEAR_BICUBIC_TOP_ASSERT_SVH

// same-cycle implication
`define ISC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("isc assertion failed");

// next-cycle implication
`define ISC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("isc assertion failed");

`endif

/* rtl/isc_pkg.sv */
// Shared types and constants for the image scaler.
// No dependencies.
package isc_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POS,
        S_WGT,
        S_FETCH,
        S_DRAIN,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        K_ONE,
        K_BIL,
        K_CUB
    } t_kind;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_W = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_H = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_W = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_H = 3'd5;

    localparam logic [1:0] MODE_NEAREST  = 2'd0;
    localparam logic [1:0] MODE_BILINEAR = 2'd1;
    localparam logic [1:0] MODE_CUBIC    = 2'd2;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    // ceil(2^22 / 6), exact floor(m/6) for m < 2^21
    localparam logic [19:0] RECIP6 = 20'd699051;

    typedef struct packed {
        logic issue;
        logic inb;
        logic clr;
    } t_isc_ctl;

endpackage

/* rtl/isc_wgt.sv */
// Cubic B-spline weight unit: four Q0.16 weights from a 16-bit fraction.
// Four-stage pipeline; depends on isc_pkg.
module isc_wgt (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [15:0]      i_t,
    output logic             o_valid,
    output logic [3:0][16:0] o_w
);
    import isc_pkg::*;

    logic [16:0] w_u;
    logic        r_v1, r_v2, r_v3, r_v4;
    logic [15:0] r_t1, r_t2s;
    logic [16:0] r_u1;
    logic [31:0] r_tt1, r_tt2;
    logic [33:0] r_uu1;
    logic [47:0] r_ttt;
    logic [50:0] r_uuu;
    logic [51:0] w_n0, w_n1, w_n2, w_n3, w_s3, w_t3, w_t2, w_t, w_rnd;
    logic [3:0][19:0] r_m;
    logic [3:0][16:0] r_w;

    assign w_u = 17'h10000 - {1'b0, i_t};

    assign w_s3  = 52'd1 << 48;
    assign w_t3  = 52'(r_ttt);
    assign w_t2  = 52'(r_tt2);
    assign w_t   = 52'(r_t2s);
    assign w_rnd = 52'd3 << 32;
    assign w_n0  = 52'(r_uuu);
    assign w_n3  = w_t3;
    assign w_n1  = 52'd3 * w_t3 + 52'd4 * w_s3 - ((52'd6 * w_t2) << 16);
    assign w_n2  = ((52'd3 * w_t2) << 16) + ((52'd3 * w_t) << 32) + w_s3 - 52'd3 * w_t3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
        if (i_valid) begin
            r_t1  <= i_t;
            r_u1  <= w_u;
            r_tt1 <= 32'(i_t) * 32'(i_t);
            r_uu1 <= 34'(w_u) * 34'(w_u);
        end
        if (r_v1) begin
            r_t2s <= r_t1;
            r_tt2 <= r_tt1;
            r_ttt <= 48'(r_tt1) * 48'(r_t1);
            r_uuu <= 51'(r_uu1) * 51'(r_u1);
        end
        if (r_v2) begin
            r_m[0] <= 20'((w_n0 + w_rnd) >> 32);
            r_m[1] <= 20'((w_n1 + w_rnd) >> 32);
            r_m[2] <= 20'((w_n2 + w_rnd) >> 32);
            r_m[3] <= 20'((w_n3 + w_rnd) >> 32);
        end
        if (r_v3) begin
            for (int k = 0; k < 4; k++) begin
                r_w[k] <= 17'((40'(r_m[k]) * 40'(RECIP6)) >> 22);
            end
        end
    end

    assign o_valid = r_v4;
    assign o_w     = r_w;

endmodule

/* rtl/isc_dp.sv */
// Image store (single-port, registered read) and weighted accumulate pipeline.
// Depends on isc_pkg.
module isc_dp #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16,
    parameter int WB    = 17,
    parameter int ACW   = 44
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic [7:0]               i_wdata,
    input  isc_pkg::t_isc_ctl        i_ctl,
    input  logic [AW-1:0]            i_raddr,
    input  logic [WB-1:0]            i_wx,
    input  logic [WB-1:0]            i_wy,
    output logic [ACW-1:0]           o_acc,
    output logic                     o_busy
);
    import isc_pkg::*;

    localparam int PW = 8 + 2 * WB;

    logic [7:0]        r_mem [0:DEPTH-1];
    logic [7:0]        r_rd;
    logic [AW-1:0]     w_addr;
    logic              r_v1, r_v2, r_v3;
    logic              r_inb1;
    logic [WB-1:0]     r_wx1, r_wy1, r_wy2;
    logic [8+WB-1:0]   r_p1;
    logic [PW-1:0]     r_p2;
    logic [ACW-1:0]    r_acc;

    assign w_addr = i_we ? i_waddr : i_raddr;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[w_addr] <= i_wdata;
        end
        r_rd <= r_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_acc <= '0;
        end else begin
            r_v1 <= i_ctl.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (i_ctl.clr) begin
                r_acc <= '0;
            end else if (r_v3) begin
                r_acc <= r_acc + ACW'(r_p2);
            end
        end
        r_inb1 <= i_ctl.inb;
        r_wx1  <= i_wx;
        r_wy1  <= i_wy;
        r_p1   <= (8 + WB)'(r_inb1 ? r_rd : 8'd0) * (8 + WB)'(r_wx1);
        r_wy2  <= r_wy1;
        r_p2   <= PW'(r_p1) * PW'(r_wy2);
    end

    assign o_acc  = r_acc;
    assign o_busy = r_v1 | r_v2 | r_v3;

endmodule

/* rtl/image_scaler_nn_bilinear_bicubic_top.sv */
// Image scaler top: config registers, sequencer, position and neighbour addressing.
// A write is stored when accepted and in range. A read computes weights, fetches N neighbours, drains
// and loads the output register (out of range goes straight to output), N = 1 (copy, nearest),
// 4 (bilinear) or 16 (cubic) fetches; the next request is accepted only after the output is loaded.
// Reset: synchronous, active low; config registers return to defaults, image undefined.
// Depends on isc_pkg, isc_wgt, isc_dp and the assertion header.
`include "image_scaler_nn_bilinear_bicubic_top_assert.svh"
module image_scaler_nn_bilinear_bicubic_top #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [31:0]                   i_s_axis_tdata,  // row[11:0], col[23:12], pixel_in[31:24]
    input  logic                          i_s_axis_tuser,  // action
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [7:0]                    o_m_axis_tdata,  // pixel_out
    output logic                          o_m_axis_tuser,  // out_of_range
    input  logic                          i_cfg_wr_en,
    input  logic [isc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [isc_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import isc_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int IXW   = 32 - FRAC_BITS;
    localparam int CW    = IXW + 6;
    localparam int WB    = (FRAC_BITS + 1 > 17) ? FRAC_BITS + 1 : 17;
    localparam int ACW   = 8 + 2 * WB + 2;
    localparam int DN    = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
    localparam int UP    = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam logic [FRAC_BITS-1:0] HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);
    localparam logic [WB-1:0]        ONE  = WB'(1) << FRAC_BITS;

    t_state r_state, n_state;

    logic [1:0]  r_mode;
    logic [19:0] r_step;
    logic [8:0]  r_src_w, r_src_h;
    logic [12:0] r_dst_w, r_dst_h;

    logic [31:0]          r_px, r_py;
    logic                 r_oor;
    t_kind                r_kind;
    logic signed [CW-1:0] r_bx, r_by;
    logic [3:0]           r_k, r_klast;
    logic                 r_ovalid, r_ouser;
    logic [7:0]           r_odata;

    logic                 w_s_acc, w_wr_ok, w_out_ld;
    logic [11:0]          w_row, w_col;
    logic [CW-1:0]        w_eff_w, w_eff_h;
    logic [AW-1:0]        w_waddr, w_raddr;
    logic [IXW-1:0]       w_ix, w_iy;
    logic [FRAC_BITS-1:0] w_fx, w_fy;
    logic [15:0]          w_tx, w_ty;
    logic                 w_wv, w_wv_y;
    logic [3:0][16:0]     w_wgx, w_wgy;
    logic [1:0]           w_dx, w_dy;
    logic signed [CW-1:0] w_cx, w_cy;
    logic                 w_inb;
    logic [WB-1:0]        w_wx, w_wy;
    t_isc_ctl             w_ctl;
    logic [ACW-1:0]       w_acc, w_shf;
    logic                 w_busy;
    logic [7:0]           w_res;

    assign w_row   = i_s_axis_tdata[11:0];
    assign w_col   = i_s_axis_tdata[23:12];
    assign w_eff_w = (32'(r_src_w) > MAX_WIDTH)  ? CW'(MAX_WIDTH)  : CW'(r_src_w);
    assign w_eff_h = (32'(r_src_h) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : CW'(r_src_h);

    assign w_s_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign w_wr_ok = w_s_acc && (i_s_axis_tuser == ACT_WRITE)
                   && (CW'(w_row) < w_eff_h) && (CW'(w_col) < w_eff_w);
    assign w_waddr = AW'(w_row[RW-1:0]) * AW'(MAX_WIDTH) + AW'(w_col[XW-1:0]);

    assign w_ix = r_px[31:FRAC_BITS];
    assign w_iy = r_py[31:FRAC_BITS];
    assign w_fx = r_px[FRAC_BITS-1:0];
    assign w_fy = r_py[FRAC_BITS-1:0];
    assign w_tx = 16'((32'(w_fx) >> DN) << UP);
    assign w_ty = 16'((32'(w_fy) >> DN) << UP);

    // neighbour walk
    assign w_dx  = (r_kind == K_CUB) ? r_k[1:0] : {1'b0, r_k[0]};
    assign w_dy  = (r_kind == K_CUB) ? r_k[3:2] : {1'b0, r_k[1]};
    assign w_cx  = r_bx + $signed(CW'(w_dx));
    assign w_cy  = r_by + $signed(CW'(w_dy));
    assign w_inb = (w_cx >= 0) && (w_cy >= 0)
                 && (w_cx < $signed(w_eff_w)) && (w_cy < $signed(w_eff_h));
    assign w_raddr = AW'(w_cy[RW-1:0]) * AW'(MAX_WIDTH) + AW'(w_cx[XW-1:0]);

    always_comb begin
        case (r_kind)
            K_BIL: begin
                w_wx = w_dx[0] ? WB'(w_fx) : ONE - WB'(w_fx);
                w_wy = w_dy[0] ? WB'(w_fy) : ONE - WB'(w_fy);
            end
            K_CUB: begin
                w_wx = WB'(w_wgx[w_dx]);
                w_wy = WB'(w_wgy[w_dy]);
            end
            default: begin
                w_wx = WB'(1);
                w_wy = WB'(1);
            end
        endcase
    end

    always_comb begin
        case (r_kind)
            K_BIL:   w_shf = w_acc >> (2 * FRAC_BITS);
            K_CUB:   w_shf = (w_acc + (ACW'(1) << 31)) >> 32;
            default: w_shf = w_acc;
        endcase
    end
    assign w_res    = (w_shf > ACW'(255)) ? 8'd255 : w_shf[7:0];
    assign w_out_ld = !r_ovalid || i_m_axis_tready;

    isc_wgt u_wgt_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_state == S_POS && !r_oor),
        .i_t     (w_tx),
        .o_valid (w_wv),
        .o_w     (w_wgx)
    );

    isc_wgt u_wgt_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_state == S_POS && !r_oor),
        .i_t     (w_ty),
        .o_valid (w_wv_y),
        .o_w     (w_wgy)
    );

    isc_dp #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .WB    (WB),
        .ACW   (ACW)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_wr_ok),
        .i_waddr (w_waddr),
        .i_wdata (i_s_axis_tdata[31:24]),
        .i_ctl   (w_ctl),
        .i_raddr (w_raddr),
        .i_wx    (w_wx),
        .i_wy    (w_wy),
        .o_acc   (w_acc),
        .o_busy  (w_busy)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_s_acc && i_s_axis_tuser == ACT_READ) n_state = S_POS;
            S_POS:   n_state = r_oor ? S_OUT : S_WGT;
            S_WGT:   if (w_wv && w_wv_y) n_state = S_FETCH;
            S_FETCH: if (r_k == r_klast) n_state = S_DRAIN;
            S_DRAIN: if (!w_busy) n_state = S_OUT;
            S_OUT:   if (w_out_ld) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_axis_tready = (r_state == S_IDLE);
        w_ctl.issue     = (r_state == S_FETCH);
        w_ctl.inb       = w_inb;
        w_ctl.clr       = (r_state == S_WGT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_k      <= '0;
            r_mode   <= MODE_BILINEAR;
            r_step   <= 20'd65536;
            r_src_w  <= 9'd256;
            r_src_h  <= 9'd256;
            r_dst_w  <= 13'd256;
            r_dst_h  <= 13'd256;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_MODE:  r_mode  <= i_cfg_wdata[1:0];
                    CFG_STEP:  r_step  <= i_cfg_wdata[19:0];
                    CFG_SRC_W: r_src_w <= i_cfg_wdata[8:0];
                    CFG_SRC_H: r_src_h <= i_cfg_wdata[8:0];
                    CFG_DST_W: r_dst_w <= i_cfg_wdata[12:0];
                    CFG_DST_H: r_dst_h <= i_cfg_wdata[12:0];
                    default: ;
                endcase
            end
            if (r_state == S_WGT) begin
                r_k <= '0;
            end else if (r_state == S_FETCH) begin
                r_k <= r_k + 4'd1;
            end
            if (r_state == S_OUT && w_out_ld) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
        if (w_s_acc) begin
            r_px  <= 32'(w_col) * 32'(r_step);
            r_py  <= 32'(w_row) * 32'(r_step);
            r_oor <= (13'(w_row) >= r_dst_h) || (13'(w_col) >= r_dst_w);
        end
        if (r_state == S_POS) begin
            if (w_fx == '0 && w_fy == '0) begin
                r_kind  <= K_ONE;
                r_klast <= 4'd0;
                r_bx    <= $signed(CW'(w_ix));
                r_by    <= $signed(CW'(w_iy));
            end else if (r_mode == MODE_NEAREST) begin
                r_kind  <= K_ONE;
                r_klast <= 4'd0;
                r_bx    <= $signed(CW'(w_ix) + CW'(w_fx > HALF));
                r_by    <= $signed(CW'(w_iy) + CW'(w_fy > HALF));
            end else if (r_mode == MODE_CUBIC) begin
                r_kind  <= K_CUB;
                r_klast <= 4'd15;
                r_bx    <= $signed(CW'(w_ix)) - $signed(CW'(1));
                r_by    <= $signed(CW'(w_iy)) - $signed(CW'(1));
            end else begin
                r_kind  <= K_BIL;
                r_klast <= 4'd3;
                r_bx    <= $signed(CW'(w_ix));
                r_by    <= $signed(CW'(w_iy));
            end
        end
        if (r_state == S_OUT && w_out_ld) begin
            r_odata <= r_oor ? 8'd0 : w_res;
            r_ouser <= r_oor;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;

    `ISC_ASSERT_IMPL(a_flag_zero, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tdata == 8'd0)
    `ISC_ASSERT_IMPL(a_k_bound, r_state == S_FETCH, r_k <= r_klast)
    `ISC_ASSERT_NEXT(a_fetch_end, r_state == S_FETCH && r_k == r_klast, r_state == S_DRAIN)
    `ISC_ASSERT_IMPL(a_drained, r_state == S_OUT, !w_busy)

endmodule
